FILE: hdl/qpam_pkg.sv
// Package: widths, types and shared constants for the quaternion pose core.
package qpam_pkg;

  localparam int WordW = 32;
  localparam int ProdW = 64;            // one signed 32x32 product
  localparam int MagW  = 66;            // sum of four squares, and magnitude of any S entry
  localparam int FracBits = 30;         // Q2.30 output
  localparam int QuotW = FracBits + 1;  // integer bit plus fraction bits
  localparam int NumRot = 9;
  localparam int DivStagesDefault = FracBits + 2;  // integer bit, fractions, round bit

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [MagW-1:0] mag_t;

  // Translation words that ride alongside the rotation math.
  typedef struct packed {
    word_t tx;
    word_t ty;
    word_t tz;
  } trans_t;

endpackage

FILE: hdl/qpam_products.sv
// Pipeline front: pairwise quaternion products, then scaled matrix entries and magnitude.
module qpam_products (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  qpam_pkg::word_t       w,
  input  qpam_pkg::word_t       a,
  input  qpam_pkg::word_t       b,
  input  qpam_pkg::word_t       c,
  input  qpam_pkg::trans_t      trans_in,
  output logic                  out_valid,
  output qpam_pkg::mag_t        den,
  output logic [qpam_pkg::NumRot-1:0] num_neg,
  output qpam_pkg::mag_t        num_mag [qpam_pkg::NumRot],
  output qpam_pkg::trans_t      trans_out
);
  import qpam_pkg::*;

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [MagW:0] sum_t;

  // stage 1: ten products
  logic  v1;
  prod_t w2, a2, b2, c2, ab, wc, ac, wb, bc, wa;
  trans_t t1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      w2 <= prod_t'(w) * prod_t'(w); a2 <= prod_t'(a) * prod_t'(a);
      b2 <= prod_t'(b) * prod_t'(b); c2 <= prod_t'(c) * prod_t'(c);
      ab <= prod_t'(a) * prod_t'(b); wc <= prod_t'(w) * prod_t'(c);
      ac <= prod_t'(a) * prod_t'(c);
      wb <= prod_t'(w) * prod_t'(b); bc <= prod_t'(b) * prod_t'(c);
      wa <= prod_t'(w) * prod_t'(a);
      t1 <= trans_in;
    end
  end

  // stage 2: sums, sign and magnitude
  sum_t s [NumRot];
  sum_t m;

  always_comb begin
    m    = sum_t'(w2) + sum_t'(a2) + sum_t'(b2) + sum_t'(c2);
    s[0] = sum_t'(w2) + sum_t'(a2) - sum_t'(b2) - sum_t'(c2);
    s[1] = (sum_t'(ab) + sum_t'(wc)) <<< 1;
    s[2] = (sum_t'(ac) - sum_t'(wb)) <<< 1;
    s[3] = (sum_t'(ab) - sum_t'(wc)) <<< 1;
    s[4] = sum_t'(w2) + sum_t'(b2) - sum_t'(a2) - sum_t'(c2);
    s[5] = (sum_t'(bc) + sum_t'(wa)) <<< 1;
    s[6] = (sum_t'(ac) + sum_t'(wb)) <<< 1;
    s[7] = (sum_t'(bc) - sum_t'(wa)) <<< 1;
    s[8] = sum_t'(w2) + sum_t'(c2) - sum_t'(a2) - sum_t'(b2);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v1;
    if (en) begin
      den       <= m[MagW-1:0];
      trans_out <= t1;
      for (int i = 0; i < NumRot; i++) begin
        num_neg[i] <= s[i][MagW];
        num_mag[i] <= s[i][MagW] ? mag_t'(-s[i]) : s[i][MagW-1:0];
      end
    end
  end

endmodule

FILE: hdl/qpam_divider.sv
// Pipelined restoring divider: one quotient bit per stage, round half away, sign fixup.
module qpam_divider (
  input  logic                  clk,
  input  logic                  en,
  input  qpam_pkg::mag_t        den,
  input  logic                  neg,
  input  qpam_pkg::mag_t        mag,
  output qpam_pkg::word_t       quot
);
  import qpam_pkg::*;

  localparam int Stages = DivStagesDefault;

  // Partial remainder stays below den, so one extra bit holds 2*rem.
  logic [MagW:0]  rem [Stages];
  mag_t           dd  [Stages];
  logic [QuotW:0] q   [Stages];
  logic           sg  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [MagW:0]  r_in;
    logic [QuotW:0] q_in;
    logic [MagW:0]  trial;
    logic           ge;
    mag_t           d_in;
    logic           s_in;
    if (k == 0) begin : g_first
      assign r_in = {1'b0, mag};
      assign q_in = '0;
      assign d_in = den;
      assign s_in = neg;
    end else begin : g_next
      assign r_in = rem[k-1] << 1;
      assign q_in = q[k-1];
      assign d_in = dd[k-1];
      assign s_in = sg[k-1];
    end
    assign ge    = r_in >= {1'b0, d_in};
    assign trial = r_in - {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? trial : r_in;
        q[k]   <= {q_in[QuotW-1:0], ge};
        dd[k]  <= d_in;
        sg[k]  <= s_in;
      end
    end
  end

  // last stage bit is the round bit: add it to the truncated quotient
  logic [QuotW:0] q_rnd;
  always_comb q_rnd = {1'b0, q[Stages-1][QuotW:1]} + {{QuotW{1'b0}}, q[Stages-1][0]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (dd[Stages-1] == '0) quot <= '0;
      else if (sg[Stages-1]) quot <= word_t'(-q_rnd);
      else quot <= word_t'(q_rnd);
    end
  end

endmodule

FILE: hdl/quaternion_pose_to_affine_matrix_core.sv
// Top level: quaternion pose to 3x4 affine matrix, fully pipelined.
// Takes one word per cycle and returns one word per cycle at full throughput,
// whenever the output is not stalled. Its stages are the ten products, the
// matrix sums, the quotient bits in the nine parallel dividers (integer bit,
// 30 fraction bits, round bit), rounding and sign, and the output register.
// The whole pipe advances together whenever the output register is empty or
// being drained, so a stall holds every stage.
// A zero quaternion yields a zero rotation; translation passes straight through.
module quaternion_pose_to_affine_matrix_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qpam_pkg::word_t trans_x,
  input  qpam_pkg::word_t trans_y,
  input  qpam_pkg::word_t trans_z,
  input  qpam_pkg::word_t quat_real,
  input  qpam_pkg::word_t quat_i,
  input  qpam_pkg::word_t quat_j,
  input  qpam_pkg::word_t quat_k,
  output logic            out_valid,
  input  logic            out_ready,
  output qpam_pkg::word_t rot_00,
  output qpam_pkg::word_t rot_01,
  output qpam_pkg::word_t rot_02,
  output qpam_pkg::word_t rot_10,
  output qpam_pkg::word_t rot_11,
  output qpam_pkg::word_t rot_12,
  output qpam_pkg::word_t rot_20,
  output qpam_pkg::word_t rot_21,
  output qpam_pkg::word_t rot_22,
  output qpam_pkg::word_t col_tx,
  output qpam_pkg::word_t col_ty,
  output qpam_pkg::word_t col_tz
);
  import qpam_pkg::*;

  localparam int Stages = DivStagesDefault;

  // Global advance: the pipe moves when the output slot is free or draining.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  trans_t trans_in;
  assign trans_in = '{tx: trans_x, ty: trans_y, tz: trans_z};

  // front end: products and sums
  logic   pv;
  mag_t   den;
  logic [NumRot-1:0] nneg;
  mag_t   nmag [NumRot];
  trans_t pt;

  qpam_products u_prod (
    .clk, .rst, .en,
    .in_valid (in_valid && in_ready),
    .w (quat_real), .a (quat_i), .b (quat_j), .c (quat_k),
    .trans_in,
    .out_valid (pv), .den, .num_neg (nneg), .num_mag (nmag), .trans_out (pt)
  );

  // nine dividers share timing; valid and translation ride a matching delay line
  word_t quot [NumRot];
  for (genvar r = 0; r < NumRot; r++) begin : g_div
    qpam_divider u_div (
      .clk, .en, .den, .neg (nneg[r]), .mag (nmag[r]), .quot (quot[r])
    );
  end

  // divider depth is Stages plus its rounding register
  localparam int DlyD = Stages + 1;
  logic   dv [DlyD];
  trans_t dt [DlyD];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DlyD; i++) dv[i] <= 1'b0;
    end else if (en) begin
      dv[0] <= pv;
      for (int i = 1; i < DlyD; i++) dv[i] <= dv[i-1];
    end
    if (en) begin
      dt[0] <= pt;
      for (int i = 1; i < DlyD; i++) dt[i] <= dt[i-1];
    end
  end

  // output register
  word_t  rot_q [NumRot];
  trans_t t_q;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[DlyD-1];
    if (en) begin
      rot_q <= quot;
      t_q   <= dt[DlyD-1];
    end
  end

  assign rot_00 = rot_q[0];
  assign rot_01 = rot_q[1];
  assign rot_02 = rot_q[2];
  assign rot_10 = rot_q[3];
  assign rot_11 = rot_q[4];
  assign rot_12 = rot_q[5];
  assign rot_20 = rot_q[6];
  assign rot_21 = rot_q[7];
  assign rot_22 = rot_q[8];
  assign col_tx = t_q.tx;
  assign col_ty = t_q.ty;
  assign col_tz = t_q.tz;

`ifndef ASSERT_OFF
  localparam word_t One = word_t'(1) <<< FracBits;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_00) && $stable(col_tx))
    else $error("output word changed while stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output slot");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rot_00 <= One && rot_00 >= -One && rot_11 <= One && rot_11 >= -One)
    else $error("rotation entry out of range");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    en && dv[DlyD-1] |=> out_valid)
    else $error("finished word dropped");
`endif

endmodule

FILE: tb/tb_top.sv
// Testbench for the quaternion pose to affine matrix core: scoreboard, drivers, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qpam_pkg::*;

  // One expected 3x4 matrix: nine rotation entries, then the translation column.
  typedef struct {
    word_t rot [NumRot];
    word_t col [3];
  } matrix_t;

  // Keeps the matrices still owed by the block, oldest first.
  class pose_scoreboard;
    matrix_t pending_matrices[$];
    int      mismatches;
    int      poses_noted;
    int      matrices_checked;
    int      zero_quats;

    // round(s * 2^30 / m), ties away from zero; zero magnitude gives zero
    function automatic word_t scale_entry(logic signed [127:0] s, logic [127:0] m);
      logic [127:0] mag;
      logic [127:0] quo;
      logic [127:0] rem;
      if (m == 0) return '0;
      mag = (s < 0) ? -s : s;
      quo = (mag << FracBits) / m;
      rem = (mag << FracBits) % m;
      if ((rem << 1) >= m) quo = quo + 1;
      return (s < 0) ? -quo[WordW-1:0] : quo[WordW-1:0];
    endfunction

    function void note_pose(word_t tx, word_t ty, word_t tz,
                            word_t qw, word_t qa, word_t qb, word_t qc);
      logic signed [127:0] w;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] c;
      logic signed [127:0] sc [NumRot];
      logic [127:0]        msq;
      matrix_t             mx;
      w = qw; a = qa; b = qb; c = qc;
      msq = w*w + a*a + b*b + c*c;
      sc[0] = w*w + a*a - b*b - c*c;
      sc[1] = 2 * (a*b + w*c);
      sc[2] = 2 * (a*c - w*b);
      sc[3] = 2 * (a*b - w*c);
      sc[4] = w*w - a*a + b*b - c*c;
      sc[5] = 2 * (b*c + w*a);
      sc[6] = 2 * (a*c + w*b);
      sc[7] = 2 * (b*c - w*a);
      sc[8] = w*w - a*a - b*b + c*c;
      foreach (sc[i]) mx.rot[i] = scale_entry(sc[i], msq);
      mx.col[0] = tx; mx.col[1] = ty; mx.col[2] = tz;
      if (msq == 0) zero_quats++;
      poses_noted++;
      pending_matrices.push_back(mx);
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      if (pending_matrices.size() == 0) begin
        $display("%0t: result word with no pose outstanding", $time);
        mismatches++;
        return;
      end
      want = pending_matrices.pop_front();
      matrices_checked++;
      foreach (want.rot[i])
        if (got.rot[i] !== want.rot[i]) begin
          $display("%0t: rot entry %0d expected %h actual %h", $time, i,
                   want.rot[i], got.rot[i]);
          mismatches++;
        end
      foreach (want.col[i])
        if (got.col[i] !== want.col[i]) begin
          $display("%0t: col_t%0d expected %h actual %h", $time, i,
                   want.col[i], got.col[i]);
          mismatches++;
        end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t trans_x = '0, trans_y = '0, trans_z = '0;
  word_t quat_real = '0, quat_i = '0, quat_j = '0, quat_k = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22;
  word_t col_tx, col_ty, col_tz;

  pose_scoreboard board = new();
  bit             stimulus_done = 1'b0;

  always #5 clk = ~clk;

  quaternion_pose_to_affine_matrix_core dut (.*);

  // Monitor: both handshakes sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    matrix_t got;
    if (!rst && in_valid && in_ready)
      board.note_pose(trans_x, trans_y, trans_z, quat_real, quat_i, quat_j, quat_k);
    if (!rst && out_valid && out_ready) begin
      got.rot = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
      got.col = '{col_tx, col_ty, col_tz};
      board.check_matrix(got);
    end
  end

  // Offer one pose at a falling edge and hold it until the block takes it;
  // then idle a random number of cycles (zero keeps valid up back to back).
  task automatic send_pose(word_t tx, word_t ty, word_t tz,
                           word_t qw, word_t qa, word_t qb, word_t qc);
    int gap;
    trans_x = tx; trans_y = ty; trans_z = tz;
    quat_real = qw; quat_i = qa; quat_j = qb; quat_k = qc;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = $urandom_range(0, 6);
    if ((board.poses_noted / 64) % 2 == 1) gap = 0;  // stretches with no idling
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random quaternion part: often unit-scale, sometimes tiny, zero, full-range or extreme.
  function automatic word_t rand_part();
    case ($urandom_range(0, 7))
      0, 1, 2: return word_t'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
      3:       return word_t'($signed($urandom_range(0, 16)) - 8);
      4:       return '0;
      5:       return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return word_t'($urandom());
    endcase
  endfunction

  // Sender: directed corners first, then random poses.
  initial begin
    word_t qw, qa, qb, qc;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // zero quaternion with translation still passed through
    send_pose(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 0, 0, 0, 0);
    // identity and the half-turn about each axis
    send_pose(0, 0, 0, 32'sh1_0000, 0, 0, 0);
    send_pose(1, -1, 0, 0, 32'sh1_0000, 0, 0);
    send_pose(0, 0, 0, 0, 0, 32'sh1_0000, 0);
    send_pose(0, 0, 0, 0, 0, 0, 32'sh1_0000);
    send_pose(0, 0, 0, -32'sh1_0000, 0, 0, 0);
    // unnormalized: quarter turns and tiny lengths
    send_pose(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0);
    send_pose(0, 0, 0, 3, 0, 0, 3);
    send_pose(0, 0, 0, 1, 1, 1, 1);
    send_pose(0, 0, 0, 0, 0, 0, 1);
    send_pose(0, 0, 0, 1, -1, 1, -1);
    // extremes of every field
    send_pose(32'sh8000_0000, 32'sh7fff_ffff, -1, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000);
    send_pose(-1, -1, -1, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_pose(0, 0, 0, 32'sh8000_0000, 0, 0, 0);
    send_pose(0, 0, 0, 0, 32'sh7fff_ffff, 0, 0);
    send_pose(0, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_pose(0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    // rounding: 1/3-style fractions from small odd lengths
    send_pose(0, 0, 0, 1, 1, 1, 0);
    send_pose(0, 0, 0, 2, 1, 0, 0);
    send_pose(0, 0, 0, -1, 0, 1, 1);
    repeat (500) begin
      qw = rand_part(); qa = rand_part(); qb = rand_part(); qc = rand_part();
      if ($urandom_range(0, 19) == 0) {qw, qa, qb, qc} = '0;
      send_pose(word_t'($urandom()), word_t'($urandom()), word_t'($urandom()),
                qw, qa, qb, qc);
    end
    in_valid = 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: random ready, plus one long hold-off so the pipe fills and stalls input.
  initial begin
    int  hold;
    bit  held;
    held = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!held && board.poses_noted >= 40) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      hold = $urandom_range(0, 6);
      if ((board.matrices_checked / 80) % 2 == 1) hold = 0;  // stretches always ready
      out_ready = (hold == 0);
      repeat (hold) @(negedge clk);
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  // End of run: drain, allow for the pipe latency, then report.
  initial begin
    wait (stimulus_done);
    while (board.pending_matrices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Checked %0d matrices from %0d poses, %0d with a zero quaternion.",
             board.matrices_checked, board.poses_noted, board.zero_quats);
    $display("Random and extreme quaternions under input gaps and output stalls.");
    if (board.mismatches == 0 && board.pending_matrices.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Timeout with %0d matrices outstanding", board.pending_matrices.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
